FILE: hdl/mcr_pkg.sv
// Shared types, codes and fixed disk tables for the midpoint circle rasteriser.
// Used by every module of the block; depends on nothing.
package mcr_pkg;

    // Largest image side; larger image_size values act as this
    localparam logic [10:0] MAX_SIDE = 11'd1024;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Configuration register indexes (only the side length shapes the addresses)
    localparam logic [1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [10:0] IMAGE_SIZE_RST = 11'd512;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_FINISHED  = 2'd2,
        ST_IDLE      = 2'd3
    } t_status;

    // Job kinds passed from the front to the back
    typedef enum logic [1:0] {
        JOB_SINGLE = 2'd0,
        JOB_DISK3  = 2'd1,
        JOB_DISK5  = 2'd2,
        JOB_OCT    = 2'd3
    } t_kind;

    // Number of address candidates per job kind
    localparam logic [3:0] DISK3_CNT = 4'd5;
    localparam logic [3:0] DISK5_CNT = 4'd13;
    localparam logic [3:0] OCT_CNT   = 4'd8;

    typedef struct packed {
        logic       command;
        logic [9:0] center_x;
        logic [9:0] center_y;
        logic [9:0] radius;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [19:0] pixel_address;
        logic [1:0]  status;
        logic        last;
        logic        done_res;
    } t_out_item;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic               done;
        logic signed [10:0] x;
        logic signed [10:0] y;
        logic [9:0]         cx;
        logic [9:0]         cy;
    } t_job;

    // Fixed disk addresses for a 3x3 image with radius 1
    function automatic logic [4:0] disk3_addr(input logic [2:0] k);
        logic [4:0] a;
        unique case (k)
            3'd0:    a = 5'd1;
            3'd1:    a = 5'd3;
            3'd2:    a = 5'd4;
            3'd3:    a = 5'd5;
            3'd4:    a = 5'd7;
            default: a = 5'd0;
        endcase
        return a;
    endfunction

    // Fixed disk addresses for a 5x5 image with radius 2
    function automatic logic [4:0] disk5_addr(input logic [3:0] k);
        logic [4:0] a;
        unique case (k)
            4'd0:    a = 5'd2;
            4'd1:    a = 5'd6;
            4'd2:    a = 5'd7;
            4'd3:    a = 5'd8;
            4'd4:    a = 5'd10;
            4'd5:    a = 5'd11;
            4'd6:    a = 5'd12;
            4'd7:    a = 5'd13;
            4'd8:    a = 5'd14;
            4'd9:    a = 5'd16;
            4'd10:   a = 5'd17;
            4'd11:   a = 5'd18;
            4'd12:   a = 5'd22;
            default: a = 5'd0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/mcr_front.sv
// Front end: takes commands, holds the midpoint state and turns each command
// into one job for the back end. Depends on mcr_pkg.
module mcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  mcr_pkg::t_in_item i_item,
    input  logic [10:0]       i_side,
    output logic              o_job_push,
    output mcr_pkg::t_job     o_job
);
    import mcr_pkg::*;

    logic               r_active, n_active;
    logic signed [10:0] r_x, n_x;
    logic signed [10:0] r_y, n_y;
    logic signed [12:0] r_p, n_p;
    logic [9:0]         r_cx, n_cx;
    logic [9:0]         r_cy, n_cy;

    logic               too_large;
    logic signed [10:0] x1, y1;
    logic signed [11:0] diff;
    logic signed [12:0] p1;
    logic               fin;
    t_job               job;

    // Classify the command and work out the next midpoint step
    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_p      = r_p;
        n_cx     = r_cx;
        n_cy     = r_cy;

        too_large = {i_item.radius, 1'b0} > i_side;

        x1   = r_x + 11'sd1;
        y1   = (r_p < 0) ? r_y : r_y - 11'sd1;
        diff = (r_p < 0) ? {x1, 1'b0} : {x1, 1'b0} - {y1, 1'b0};
        p1   = r_p + {diff[11], diff} + 13'sd1;
        fin  = x1 > y1;

        job.kind   = JOB_SINGLE;
        job.status = ST_OK;
        job.done   = 1'b0;
        job.x      = x1;
        job.y      = y1;
        job.cx     = r_cx;
        job.cy     = r_cy;

        if (i_item.command == CMD_START) begin
            n_cx     = i_item.center_x;
            n_cy     = i_item.center_y;
            n_active = 1'b0;
            if (too_large) begin
                job.status = ST_TOO_LARGE;
            end else if (i_side == 11'd3 && i_item.radius == 10'd1) begin
                job.kind   = JOB_DISK3;
                job.status = ST_FINISHED;
                job.done   = 1'b1;
            end else if (i_side == 11'd5 && i_item.radius == 10'd2) begin
                job.kind   = JOB_DISK5;
                job.status = ST_FINISHED;
                job.done   = 1'b1;
            end else begin
                n_active = 1'b1;
                n_x      = '0;
                n_y      = {1'b0, i_item.radius};
                n_p      = 13'sd1 - $signed({3'b000, i_item.radius});
            end
        end else if (!r_active) begin
            job.status = ST_IDLE;
        end else begin
            n_x        = x1;
            n_y        = y1;
            n_p        = p1;
            n_active   = !fin;
            job.kind   = JOB_OCT;
            job.status = fin ? ST_FINISHED : ST_OK;
            job.done   = fin;
        end
    end

    // Hold the circle state, advance it on each accepted command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_p      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
        end else if (i_accept) begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_p      <= n_p;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
        end
    end

    assign o_job_push = i_accept;
    assign o_job      = job;

endmodule

FILE: hdl/mcr_job_fifo.sv
// Two-entry job queue between the front and the back end.
// Depends on mcr_pkg for the job type.
module mcr_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcr_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mcr_pkg::t_job o_head
);
    import mcr_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_head  = r_mem[r_rd];

endmodule

FILE: hdl/mcr_back.sv
// Back end: walks each job's address candidates through a three-stage
// address pipeline, marks the last word and queues results. Depends on mcr_pkg.
module mcr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [10:0]         i_side,
    input  logic                i_job_valid,
    input  mcr_pkg::t_job       i_job,
    output logic                o_job_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output mcr_pkg::t_out_item  o_out
);
    import mcr_pkg::*;

    typedef struct packed {
        logic               term;
        logic               fixed;
        logic [4:0]         faddr;
        logic signed [12:0] row;
        logic signed [12:0] col;
        t_status            status;
        logic               done;
    } t_stage1;

    typedef struct packed {
        logic               term;
        logic               fixed;
        logic [4:0]         faddr;
        logic signed [25:0] prod;
        logic signed [12:0] col;
        t_status            status;
        logic               done;
    } t_stage2;

    logic [3:0]  r_k;
    logic [20:0] r_area;
    t_stage1     r_s1, n_s1;
    t_stage2     r_s2;
    logic        r_s1_live, r_s2_live;
    logic        r_hold_v;
    t_out_item   r_hold;

    t_out_item   r_ofifo [4];
    logic [1:0]  r_owr, r_ord;
    logic [2:0]  r_ocnt;

    logic               adv;
    logic [3:0]         cnt;
    logic               at_end;
    logic signed [10:0] dc, dr;
    logic signed [25:0] idx;
    logic               in_rng;
    t_out_item          cand;
    logic               opush;
    t_out_item          oword;

    // Whole pipeline moves only while the result queue has a free slot
    assign adv = r_ocnt != 3'd4;

    // Candidate count of the job at the head
    always_comb begin
        unique case (i_job.kind)
            JOB_SINGLE: cnt = 4'd0;
            JOB_DISK3:  cnt = DISK3_CNT;
            JOB_DISK5:  cnt = DISK5_CNT;
            JOB_OCT:    cnt = OCT_CNT;
        endcase
    end

    assign at_end    = r_k == cnt;
    assign o_job_pop = adv && i_job_valid && at_end;

    // Octant offsets for candidate k
    always_comb begin
        unique case (r_k[2:0])
            3'd0: begin dc =  i_job.x; dr =  i_job.y; end
            3'd1: begin dc = -i_job.x; dr =  i_job.y; end
            3'd2: begin dc =  i_job.x; dr = -i_job.y; end
            3'd3: begin dc = -i_job.x; dr = -i_job.y; end
            3'd4: begin dc =  i_job.y; dr =  i_job.x; end
            3'd5: begin dc = -i_job.y; dr =  i_job.x; end
            3'd6: begin dc =  i_job.y; dr = -i_job.x; end
            3'd7: begin dc = -i_job.y; dr = -i_job.x; end
        endcase
    end

    // Issue one candidate, or the closing token, per cycle while the pipeline advances
    always_comb begin
        n_s1.term   = at_end;
        n_s1.fixed  = i_job.kind == JOB_DISK3 || i_job.kind == JOB_DISK5;
        n_s1.faddr  = (i_job.kind == JOB_DISK3) ? disk3_addr(r_k[2:0]) : disk5_addr(r_k);
        n_s1.row    = $signed({3'b000, i_job.cy}) + {{2{dr[10]}}, dr};
        n_s1.col    = $signed({3'b000, i_job.cx}) + {{2{dc[10]}}, dc};
        n_s1.status = i_job.status;
        n_s1.done   = i_job.done;
    end

    // Final index and range check
    always_comb begin
        idx    = r_s2.prod + {{13{r_s2.col[12]}}, r_s2.col};
        in_rng = r_s2.fixed || (!idx[25] && idx < $signed({5'b00000, r_area}));
        cand.pixel_valid   = 1'b1;
        cand.pixel_address = r_s2.fixed ? {15'd0, r_s2.faddr} : idx[19:0];
        cand.status        = r_s2.status;
        cand.last          = 1'b0;
        cand.done_res      = r_s2.done;
    end

    // Release the held word once a later one or the closing token shows up
    always_comb begin
        opush = 1'b0;
        oword = r_hold;
        if (adv && r_s2_live) begin
            if (r_s2.term) begin
                opush = 1'b1;
                if (r_hold_v) begin
                    oword.last = 1'b1;
                end else begin
                    oword.pixel_valid   = 1'b0;
                    oword.pixel_address = '0;
                    oword.status        = r_s2.status;
                    oword.last          = 1'b1;
                    oword.done_res      = r_s2.done;
                end
            end else if (in_rng && r_hold_v) begin
                opush      = 1'b1;
                oword.last = 1'b0;
            end
        end
    end

    // Image area, refreshed from the side length
    always_ff @(posedge i_clk) begin
        r_area <= 21'(i_side * i_side);
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2.term   <= r_s1.term;
            r_s2.fixed  <= r_s1.fixed;
            r_s2.faddr  <= r_s1.faddr;
            r_s2.prod   <= r_s1.row * $signed({2'b00, i_side});
            r_s2.col    <= r_s1.col;
            r_s2.status <= r_s1.status;
            r_s2.done   <= r_s1.done;
            r_s1        <= n_s1;
            if (r_s2_live && !r_s2.term && in_rng) begin
                r_hold <= cand;
            end
        end
        if (opush) begin
            r_ofifo[r_owr] <= oword;
        end
    end

    // Control: candidate counter, stage valids, hold flag, queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_s2_live <= 1'b0;
            r_hold_v  <= 1'b0;
            r_owr     <= '0;
            r_ord     <= '0;
            r_ocnt    <= '0;
        end else begin
            if (adv) begin
                r_s2_live <= r_s1_live;
                if (i_job_valid) begin
                    r_k <= at_end ? 4'd0 : r_k + 4'd1;
                end
                if (r_s2_live) begin
                    if (r_s2.term) begin
                        r_hold_v <= 1'b0;
                    end else if (in_rng) begin
                        r_hold_v <= 1'b1;
                    end
                end
            end
            if (opush) begin
                r_owr <= r_owr + 2'd1;
            end
            if (i_pop && !o_empty) begin
                r_ord <= r_ord + 2'd1;
            end
            r_ocnt <= r_ocnt + {2'b00, opush} - {2'b00, i_pop && !o_empty};
        end
    end

    // First-stage valid needs its own reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_live <= 1'b0;
        end else if (adv) begin
            r_s1_live <= i_job_valid;
        end
    end

    assign o_empty = r_ocnt == 3'd0;
    assign o_out   = r_ofifo[r_ord];

endmodule

FILE: hdl/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasteriser: configuration register, front
// end, job queue and back end. Depends on mcr_pkg, mcr_front, mcr_job_fifo, mcr_back.
//
// Usage:
//  - Commands enter as a queue: a word is taken on a clock edge with push high
//    and full low. Results leave as a queue: the oldest word sits on o_out while
//    empty is low and is taken on an edge with pop high.
//  - Configuration: a write on i_cfg_valid (o_cfg_ready is always high) with a
//    register index; only image_size changes the addresses, the store controls
//    live downstream. Write only while the block is idle.
//  - A start command gives one word; a fixed disk gives 5 or 13; a step gives one word
//    per octant point whose flat index lies in the image (up to 8), or one blank word.
//  - Throughput: the back end issues one address candidate per cycle while the
//    result queue has room, plus a closing token per job. A two-deep job queue
//    lets the front keep taking commands meanwhile.
//  - Path with the back end idle: a single word passes the row/column stage,
//    the multiply stage and the result queue; an address word also waits in the
//    hold stage until a later in-range point or the closing token arrives, so a
//    step's first word comes later when leading octant points fall outside.
//  - Reset clears the circle state, all queues and sets image_size to 512.
//  - When the receiver stalls, the four-word result queue fills, the back end
//    holds, then the job queue fills and full rises; nothing is lost.
module midpoint_circle_rasterizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mcr_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output mcr_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import mcr_pkg::*;

    logic [10:0] r_image_size;
    logic [10:0] side;
    logic        accept;
    logic        job_push, job_pop, job_full, job_empty;
    t_job        job_in, job_head;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= IMAGE_SIZE_RST;
        end else if (i_cfg_valid && i_cfg_index == CFG_IMAGE_SIZE) begin
            r_image_size <= i_cfg_data[10:0];
        end
    end

    assign o_cfg_ready = 1'b1;
    assign side        = (r_image_size > MAX_SIDE) ? MAX_SIDE : r_image_size;
    assign full        = job_full;
    assign accept      = push && !job_full;

    mcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in),
        .i_side     (side),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    mcr_job_fifo u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_head  (job_head)
    );

    mcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_side      (side),
        .i_job_valid (!job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking bench for midpoint_circle_rasterizer_unit: directed circles, then random
// sequences under several image sizes, each word checked against a predictor of its own.
// Depends on mcr_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    // Register indexes beyond the one the package names
    localparam logic [1:0] REG_WRITE_MODE    = 2'd1;
    localparam logic [1:0] REG_DRAW_VALUE    = 2'd2;
    localparam logic [1:0] REG_OVERLAY_SCALE = 2'd3;
    localparam int STALL_LIMIT = 2000;

    // Predicts the address words of each command and checks the words that leave
    class circle_scoreboard;
        t_out_item  expected_q[$];
        int         errors;
        bit         active;
        int         step_x;
        int         step_y;
        int         decision;
        int         held_cx;
        int         held_cy;
        logic [10:0] image_size;
        logic        write_mode;
        logic [15:0] draw_value;
        logic [16:0] overlay_scale;
        int          disk3_tbl[5];
        int          disk5_tbl[13];

        function new();
            errors        = 0;
            image_size    = 11'd512;
            write_mode    = 1'b0;
            draw_value    = 16'hFFFF;
            overlay_scale = 17'h10000;
            active        = 1'b0;
            step_x        = 0;
            step_y        = 0;
            decision      = 0;
            held_cx       = 0;
            held_cy       = 0;
            disk3_tbl     = '{1, 3, 4, 5, 7};
            disk5_tbl     = '{2, 6, 7, 8, 10, 11, 12, 13, 14, 16, 17, 18, 22};
        endfunction

        function int side();
            return (image_size > MAX_SIDE) ? int'(MAX_SIDE) : int'(image_size);
        endfunction

        function void write_reg(logic [1:0] index, logic [16:0] data);
            case (index)
                CFG_IMAGE_SIZE:    image_size = data[10:0];
                REG_WRITE_MODE:    write_mode = data[0];
                REG_DRAW_VALUE:    draw_value = data[15:0];
                REG_OVERLAY_SCALE: overlay_scale = (data > 17'h10000) ? 17'h10000 : data;
                default: ;
            endcase
        endfunction

        function void add_word(logic valid, int addr, t_status st, logic done);
            t_out_item w;
            w.pixel_valid   = valid;
            w.pixel_address = valid ? addr[19:0] : 20'd0;
            w.status        = st;
            w.last          = 1'b0;
            w.done_res      = done;
            expected_q.push_back(w);
        endfunction

        // Work out the words one accepted command causes
        function void note_input(t_in_item cmd);
            int      n;
            int      r;
            int      idx;
            int      count;
            int      dc[8];
            int      dr[8];
            bit      fin;
            t_status st;
            n     = side();
            count = 0;
            if (cmd.command == CMD_START) begin
                r       = int'(cmd.radius);
                held_cx = int'(cmd.center_x);
                held_cy = int'(cmd.center_y);
                active  = 1'b0;
                if (2 * r > n) begin
                    add_word(1'b0, 0, ST_TOO_LARGE, 1'b0);
                end else if (n == 3 && r == 1) begin
                    foreach (disk3_tbl[k]) add_word(1'b1, disk3_tbl[k], ST_FINISHED, 1'b1);
                end else if (n == 5 && r == 2) begin
                    foreach (disk5_tbl[k]) add_word(1'b1, disk5_tbl[k], ST_FINISHED, 1'b1);
                end else begin
                    active   = 1'b1;
                    step_x   = 0;
                    step_y   = r;
                    decision = 1 - r;
                    add_word(1'b0, 0, ST_OK, 1'b0);
                end
            end else if (!active) begin
                add_word(1'b0, 0, ST_IDLE, 1'b0);
            end else begin
                // advance the decision variable by one step
                step_x = step_x + 1;
                if (decision < 0) begin
                    decision = decision + 2 * step_x + 1;
                end else begin
                    step_y   = step_y - 1;
                    decision = decision + 2 * (step_x - step_y) + 1;
                end
                fin = step_x > step_y;
                st  = fin ? ST_FINISHED : ST_OK;
                if (fin) active = 1'b0;
                dc = '{step_x, -step_x, step_x, -step_x, step_y, -step_y, step_y, -step_y};
                dr = '{step_y, step_y, -step_y, -step_y, step_x, step_x, -step_x, -step_x};
                // keep only the octant points whose flat index lies in the image
                for (int k = 0; k < 8; k++) begin
                    idx = (held_cy + dr[k]) * n + (held_cx + dc[k]);
                    if (idx >= 0 && idx <= n * n - 1) begin
                        add_word(1'b1, idx, st, fin);
                        count++;
                    end
                end
                if (count == 0) add_word(1'b0, 0, st, fin);
            end
            expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        task report(string what, int got, int want);
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // Compare one word taken from the block with the oldest prediction
        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report("unexpected word, address", got.pixel_address, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.pixel_valid !== want.pixel_valid)
                report("pixel_valid", got.pixel_valid, want.pixel_valid);
            if (got.pixel_address !== want.pixel_address)
                report("pixel_address", got.pixel_address, want.pixel_address);
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.last !== want.last)
                report("last", got.last, want.last);
            if (got.done_res !== want.done_res)
                report("done_res", got.done_res, want.done_res);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_IMAGE_SIZE;
    logic [16:0] i_cfg_data = '0;

    circle_scoreboard sb;
    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int stall_cycles = 0;

    midpoint_circle_rasterizer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Take result words, stalling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) sb.check_result(o_out);
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL midpoint_circle_rasterizer_unit");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one command word, idling first at random; push stays high on return
    task automatic send_word(t_in_item w);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(w);
        items_sent++;
    endtask

    task automatic start_at(int cx, int cy, int r);
        t_in_item w;
        w.command  = CMD_START;
        w.center_x = cx[9:0];
        w.center_y = cy[9:0];
        w.radius   = r[9:0];
        send_word(w);
    endtask

    // Step commands carry random filler in the unused fields
    task automatic step_once();
        t_in_item w;
        w.command  = CMD_STEP;
        w.center_x = 10'($urandom_range(1023));
        w.center_y = 10'($urandom_range(1023));
        w.radius   = 10'($urandom_range(1023));
        send_word(w);
    endtask

    // Hold off the sender until every predicted word has been taken
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_word(logic [1:0] index, logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(index, data);
    endtask

    task automatic configure(logic [10:0] size, logic mode, logic [15:0] draw,
                             logic [16:0] scale);
        cfg_word(CFG_IMAGE_SIZE, {6'd0, size});
        cfg_word(REG_WRITE_MODE, {16'd0, mode});
        cfg_word(REG_DRAW_VALUE, {1'b0, draw});
        cfg_word(REG_OVERLAY_SCALE, scale);
        i_cfg_valid <= 1'b0;
    endtask

    // Centre mostly inside the image, sometimes anywhere
    function automatic int pick_centre(int n);
        if (n > 0 && $urandom_range(3) != 0) return $urandom_range(n - 1);
        return $urandom_range(1023);
    endfunction

    // Random circles: mostly complete ones, with abandoned, oversized and stray commands
    task automatic run_circles(int count);
        int       goal;
        int       n;
        int       rmax;
        int       r;
        int       pick;
        t_in_item w;
        goal = items_sent + count;
        while (items_sent < goal) begin
            n    = sb.side();
            rmax = n / 2;
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(9) == 0)
                    r = $urandom_range(rmax < 100 ? rmax : 100);
                else
                    r = $urandom_range(rmax < 12 ? rmax : 12);
                start_at(pick_centre(n), pick_centre(n), r);
                while (sb.active && items_sent < goal + 80) begin
                    if ($urandom_range(24) == 0) break;
                    step_once();
                end
                if ($urandom_range(4) == 0) step_once();
            end else if (pick < 80 && rmax < 1023) begin
                start_at(pick_centre(n), pick_centre(n), $urandom_range(1023, rmax + 1));
            end else if (pick < 90) begin
                step_once();
            end else begin
                w.command  = 1'($urandom_range(1));
                w.center_x = 10'($urandom_range(1023));
                w.center_y = 10'($urandom_range(1023));
                w.radius   = 10'($urandom_range(1023));
                send_word(w);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: idle step, zero radius, wrap and edge centres
        send_idle = 19;
        recv_idle = 88;
        step_once();
        start_at(0, 0, 0);
        step_once();
        start_at(1023, 0, 2);
        step_once();
        step_once();
        step_once();
        start_at(1023, 1023, 1023);
        start_at(511, 511, 256);
        step_once();
        start_at(5, 5, 1);
        step_once();

        // Smallest fixed disk, then an oversized radius
        drain();
        configure(11'd3, 1'b1, 16'h0000, 17'h1FFFF);
        start_at(1023, 1023, 1);
        start_at(1, 1, 2);
        step_once();

        // Larger fixed disk and an ordinary circle on the same small image
        drain();
        configure(11'd5, 1'b0, 16'hFFFF, 17'h00000);
        start_at(0, 0, 2);
        start_at(2, 2, 1);
        step_once();

        // Empty image: nothing can land
        drain();
        configure(11'd0, 1'b1, 16'h5A5A, 17'h10000);
        start_at(0, 0, 0);
        step_once();

        // Side above the maximum clamps to it
        drain();
        configure(11'h7FF, 1'b0, 16'hA5A5, 17'h0FFFF);
        start_at(512, 512, 512);
        step_once();
        step_once();
        start_at(512, 512, 513);

        drain();
        configure(11'd1, 1'b1, 16'h1234, 17'h08000);
        start_at(0, 0, 0);
        step_once();

        // Random part: receiver mostly stalled
        drain();
        configure(11'd16, 1'b1, 16'h0000, 17'h1FFFF);
        run_circles(50);
        drain();
        configure(11'd3, 1'b0, 16'hFFFF, 17'h00000);
        run_circles(50);

        // Sender mostly idle
        send_idle = 88;
        recv_idle = 19;
        drain();
        configure(11'd5, 1'b1, 16'h5A5A, 17'h10000);
        run_circles(50);
        drain();
        configure(11'd1024, 1'b0, 16'hA5A5, 17'h0FFFF);
        run_circles(50);

        // Full rate on both sides
        send_idle = 0;
        recv_idle = 0;
        drain();
        configure(11'($urandom_range(64, 1)), 1'($urandom_range(1)),
                  16'($urandom_range(65535)), 17'($urandom_range(131071)));
        run_circles(50);
        drain();
        configure(11'h7FF, 1'b1, 16'($urandom_range(65535)), 17'($urandom_range(65536)));
        run_circles(50);

        // Let stray words surface, then judge
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS midpoint_circle_rasterizer_unit");
        end else begin
            $display("FAIL midpoint_circle_rasterizer_unit");
        end
        $finish;
    end

endmodule
